### rtl/open_address_hash_table_unit_macros.svh
// Assertion macros shared by the hash table RTL.
`ifndef OPEN_ADDRESS_HASH_TABLE_UNIT_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_UNIT_MACROS_SVH

// Condition holds at every edge out of reset.
`define OAHT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define OAHT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define OAHT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/oaht_pkg.sv
// Types, constants and helpers for the open-address hash table.
`default_nettype none

package oaht_pkg;

    localparam int SLOTS       = 1024;
    localparam int KEY_BITS    = 32;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int LG_W        = $clog2(SIZE_W + 1);
    localparam int HASH_W      = 32;
    localparam int KEY_IN_W    = 32;
    localparam int KEY_W       = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int VAL_W       = 32;
    localparam int BIT_CNT_W   = $clog2(HASH_W);
    localparam int TS_W        = 11;
    localparam int LIM_W       = 7;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int SLOT_OUT_W  = 10;
    localparam int PROD_W      = SIZE_W + LIM_W + 1;
    localparam int SIZE_MIN    = 3;
    localparam int SIZE_RESET  = 1021;
    localparam int LIMIT_RESET = 80;
    localparam int PERCENT     = 100;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        RQ_INSERT = 2'd0,
        RQ_SET    = 2'd1,
        RQ_DELETE = 2'd2,
        RQ_LOOKUP = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        RS_OK        = 2'd0,
        RS_NOT_FOUND = 2'd1,
        RS_FULL      = 2'd2
    } t_rsp_status;

    typedef enum logic [1:0] {
        SS_EMPTY = 2'd0,
        SS_TOMB  = 2'd1,
        SS_FULL  = 2'd2
    } t_slot_st;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_VAL,
        WR_TOMB
    } t_wr_op;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK,
        B_WRITE,
        B_THR,
        B_OUT
    } t_bstate;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [LG_W-1:0]   lg;
        logic [LIM_W-1:0]  limit;
    } t_cfg;

    typedef struct packed {
        t_req_type         req;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  start;
        logic [IDX_W-1:0]  step;
    } t_job;

    function automatic logic [LG_W-1:0] floor_log2(input logic [SIZE_W-1:0] x);
        logic [LG_W-1:0] r;
        r = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (x[i]) r = LG_W'(i);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/oaht_ifs.sv
// Request and response channel interfaces.
`default_nettype none

interface oaht_req_if import oaht_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [HASH_W-1:0]   key_hash;
    logic [KEY_IN_W-1:0] key;
    logic [VAL_W-1:0]    value;

    modport source (output valid, req_type, key_hash, key, value, input ready);
    modport sink   (input valid, req_type, key_hash, key, value, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [VAL_W-1:0]      found_value;
    logic                  over_threshold;

    modport source (output valid, status, slot_index, found_value, over_threshold,
                     input ready);
    modport sink   (input valid, status, slot_index, found_value, over_threshold,
                     output ready);
endinterface

`default_nettype wire

### rtl/open_address_hash_table_unit.sv
// Top level of the open-address hash table: configuration and channel wiring.
//
//  channel   dir  handshake      beat
//  i_req     in   valid/ready    req_type, key_hash, key, value
//  o_rsp     out  valid/ready    status, slot_index, found_value, over_threshold
//  i_cfg_*   in   write enable   register index, data
//
//  Front end: accepts a request, reduces the hash one bit per cycle, then hands
//  the job to the queue; no new request is taken until the queue has the job.
//  Back end: read and check per probe (registered slot RAM read), then commit.
//  The front end reduces the next hash while the back end probes.
//  After reset a pass clears every slot state; no beat is taken then.
//  A stalled response holds the back end in its output stage.
`default_nettype none

module open_address_hash_table_unit import oaht_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    oaht_req_if.sink             i_req,
    oaht_rsp_if.source           o_rsp
);

    logic [TS_W-1:0]  r_table_size;
    logic [LIM_W-1:0] r_fill_limit;
    t_cfg             cfg;
    logic             push, pop, q_empty, q_full, clear_done;
    t_job             push_job, pop_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TS_W'(SIZE_RESET);
            r_fill_limit <= LIM_W'(LIMIT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TABLE_SIZE: r_table_size <= i_cfg_data[TS_W-1:0];
                CFG_FILL_LIMIT: r_fill_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(r_table_size) < SIZE_MIN)   cfg.size = SIZE_W'(SIZE_MIN);
        else if (32'(r_table_size) > SLOTS) cfg.size = SIZE_W'(SLOTS);
        else                                cfg.size = SIZE_W'(r_table_size);
        cfg.lg    = floor_log2(cfg.size);
        cfg.limit = r_fill_limit;
    end

    oaht_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .i_clear_done(clear_done),
        .i_req(i_req), .o_push(push), .o_job(push_job), .i_full(q_full)
    );

    oaht_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(push_job),
        .i_pop(pop), .o_job(pop_job), .o_empty(q_empty), .o_full(q_full)
    );

    oaht_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .i_empty(q_empty),
        .i_job(pop_job), .o_pop(pop), .o_clear_done(clear_done), .o_rsp(o_rsp)
    );

endmodule

`default_nettype wire

### rtl/oaht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module oaht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/oaht_fifo.sv
// Short job queue between the front and back ends.
`default_nettype none
`include "open_address_hash_table_unit_macros.svh"

module oaht_fifo import oaht_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    assign o_job   = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));

    `OAHT_IMPLIES(a_no_overflow, i_push, !o_full, "push into full queue")
    `OAHT_IMPLIES(a_no_underflow, i_pop, !o_empty, "pop from empty queue")

endmodule

`default_nettype wire

### rtl/oaht_front.sv
// Front end: accepts requests and reduces the hash to start slot and step.
`default_nettype none

module oaht_front import oaht_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  logic           i_clear_done,
    oaht_req_if.sink       i_req,
    output logic           o_push,
    output t_job           o_job,
    input  logic           i_full
);

    t_fstate              r_state, n_state;
    logic [HASH_W-1:0]    r_hash;
    logic [IDX_W-1:0]     r_rem_s;
    logic [LG_W-1:0]      r_rem_l;
    logic [BIT_CNT_W-1:0] r_cnt;
    t_req_type            r_req;
    logic [KEY_W-1:0]     r_key;
    logic [VAL_W-1:0]     r_value;

    logic                 accept;
    logic [SIZE_W-1:0]    try_s;
    logic [LG_W:0]        try_l;
    logic [IDX_W-1:0]     n_rem_s;
    logic [LG_W-1:0]      n_rem_l;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_DIV;
            F_DIV:  if (r_cnt == BIT_CNT_W'(HASH_W - 1)) n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        o_push      = 1'b0;
        unique case (r_state)
            F_IDLE:  i_req.ready = i_clear_done;
            F_PUSH:  o_push = !i_full;
            default: ;
        endcase
    end

    assign accept = i_req.valid && i_req.ready;

    // restoring remainder, one hash bit per cycle, against size and floor(log2(size))
    always_comb begin
        try_s   = {r_rem_s, r_hash[HASH_W-1]};
        try_l   = {r_rem_l, r_hash[HASH_W-1]};
        n_rem_s = (try_s >= i_cfg.size) ? IDX_W'(try_s - i_cfg.size) : IDX_W'(try_s);
        n_rem_l = (try_l >= {1'b0, i_cfg.lg}) ? LG_W'(try_l - {1'b0, i_cfg.lg})
                                               : LG_W'(try_l);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hash  <= i_req.key_hash;
            r_req   <= t_req_type'(i_req.req_type);
            r_key   <= i_req.key[KEY_W-1:0];
            r_value <= i_req.value;
            r_rem_s <= '0;
            r_rem_l <= '0;
            r_cnt   <= '0;
        end else if (r_state == F_DIV) begin
            r_hash  <= {r_hash[HASH_W-2:0], 1'b0};
            r_rem_s <= n_rem_s;
            r_rem_l <= n_rem_l;
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    assign o_job.req   = r_req;
    assign o_job.key   = r_key;
    assign o_job.value = r_value;
    assign o_job.start = r_rem_s;
    assign o_job.step  = IDX_W'(1) << r_rem_l;

endmodule

`default_nettype wire

### rtl/oaht_back.sv
// Back end: walks the probe chain, updates the slot stores, drives responses.
`default_nettype none
`include "open_address_hash_table_unit_macros.svh"

module oaht_back import oaht_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_empty,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_clear_done,
    oaht_rsp_if.source o_rsp
);

    t_bstate           r_state, n_state;
    logic [IDX_W-1:0]  r_clr;
    t_job              r_job;
    logic [IDX_W-1:0]  r_idx;
    logic [SIZE_W-1:0] r_cnt;
    logic              r_have_free;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_free_empty;
    t_wr_op            r_op;
    logic              r_fill_inc;
    logic [IDX_W-1:0]  r_wr_idx;
    t_rsp_status       r_status;
    logic [VAL_W-1:0]  r_fval;
    logic [SIZE_W-1:0] r_fill;
    logic [PROD_W-1:0] r_pa;
    logic [PROD_W-1:0] r_pb;

    logic              r_out_valid;
    t_rsp_status       r_out_status;
    logic [IDX_W-1:0]  r_out_slot;
    logic [VAL_W-1:0]  r_out_fval;
    logic              r_out_thr;

    logic [1:0]        stat_rd;
    logic [KEY_W-1:0]  key_rd;
    logic [VAL_W-1:0]  val_rd;
    logic              stat_we, key_we, val_we;
    logic [IDX_W-1:0]  waddr;
    logic [1:0]        stat_wd;

    t_slot_st          st;
    logic              match, nonfull, free_ok, free_empty, last, stop, load_out;
    logic [IDX_W-1:0]  free_idx;
    logic [SIZE_W-1:0] idx_sum;
    logic [IDX_W-1:0]  idx_next;

    oaht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_stat_ram (
        .i_clk(i_clk), .i_we(stat_we), .i_waddr(waddr), .i_wdata(stat_wd),
        .i_raddr(r_idx), .o_rdata(stat_rd)
    );

    oaht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(waddr), .i_wdata(r_job.key),
        .i_raddr(r_idx), .o_rdata(key_rd)
    );

    oaht_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val_ram (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(waddr), .i_wdata(r_job.value),
        .i_raddr(r_idx), .o_rdata(val_rd)
    );

    always_comb begin
        st         = t_slot_st'(stat_rd);
        nonfull    = (st != SS_FULL);
        match      = (st == SS_FULL) && (key_rd == r_job.key) && (r_job.req != RQ_INSERT);
        free_ok    = r_have_free || nonfull;
        free_idx   = r_have_free ? r_free_idx : r_idx;
        free_empty = r_have_free ? r_free_empty : (st == SS_EMPTY);
        last       = ((r_cnt + 1'b1) == i_cfg.size);
        stop       = match || (st == SS_EMPTY) || ((r_job.req == RQ_INSERT) && nonfull)
                     || last;
        idx_sum    = SIZE_W'(r_idx) + SIZE_W'(r_job.step);
        idx_next   = (idx_sum >= i_cfg.size) ? IDX_W'(idx_sum - i_cfg.size)
                                             : IDX_W'(idx_sum);
        load_out   = (r_state == B_OUT) && (!r_out_valid || o_rsp.ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: if (r_clr == IDX_W'(SLOTS - 1)) n_state = B_IDLE;
            B_IDLE:  if (!i_empty) n_state = B_READ;
            B_READ:  n_state = B_CHECK;
            B_CHECK: n_state = stop ? B_WRITE : B_READ;
            B_WRITE: n_state = B_THR;
            B_THR:   n_state = B_OUT;
            B_OUT:   if (load_out) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        stat_we = 1'b0;
        key_we  = 1'b0;
        val_we  = 1'b0;
        waddr   = r_wr_idx;
        stat_wd = SS_FULL;
        unique case (r_state)
            B_CLEAR: begin
                stat_we = 1'b1;
                waddr   = r_clr;
                stat_wd = SS_EMPTY;
            end
            B_IDLE:  o_pop = !i_empty;
            B_WRITE: begin
                stat_we = (r_op == WR_NEW) || (r_op == WR_TOMB);
                key_we  = (r_op == WR_NEW);
                val_we  = (r_op == WR_NEW) || (r_op == WR_VAL);
                stat_wd = (r_op == WR_TOMB) ? SS_TOMB : SS_FULL;
            end
            default: ;
        endcase
    end

    assign o_clear_done = (r_state != B_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) r_clr <= r_clr + 1'b1;
            if ((r_state == B_WRITE) && r_fill_inc) r_fill <= r_fill + 1'b1;
            if (load_out)         r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job       <= i_job;
                r_idx       <= i_job.start;
                r_cnt       <= '0;
                r_have_free <= 1'b0;
            end
            B_CHECK: begin
                if (stop) begin
                    if (match) begin
                        r_wr_idx   <= r_idx;
                        r_fill_inc <= 1'b0;
                        r_status   <= RS_OK;
                        case (r_job.req)
                            RQ_SET: begin
                                r_op   <= WR_VAL;
                                r_fval <= '0;
                            end
                            RQ_DELETE: begin
                                r_op   <= WR_TOMB;
                                r_fval <= '0;
                            end
                            default: begin
                                r_op   <= WR_NONE;
                                r_fval <= val_rd;
                            end
                        endcase
                    end else if ((r_job.req == RQ_INSERT) || (r_job.req == RQ_SET)) begin
                        r_fval <= '0;
                        if (free_ok) begin
                            r_op       <= WR_NEW;
                            r_wr_idx   <= free_idx;
                            r_fill_inc <= free_empty;
                            r_status   <= RS_OK;
                        end else begin
                            r_op       <= WR_NONE;
                            r_wr_idx   <= '0;
                            r_fill_inc <= 1'b0;
                            r_status   <= RS_FULL;
                        end
                    end else begin
                        r_op       <= WR_NONE;
                        r_wr_idx   <= '0;
                        r_fill_inc <= 1'b0;
                        r_fval     <= '0;
                        r_status   <= RS_NOT_FOUND;
                    end
                end else begin
                    r_idx <= idx_next;
                    r_cnt <= r_cnt + 1'b1;
                    if (nonfull && !r_have_free) begin
                        r_have_free  <= 1'b1;
                        r_free_idx   <= r_idx;
                        r_free_empty <= (st == SS_EMPTY);
                    end
                end
            end
            B_THR: begin
                r_pa <= PROD_W'(r_fill) * PROD_W'(PERCENT);
                r_pb <= (PROD_W'(i_cfg.limit) + PROD_W'(1)) * PROD_W'(i_cfg.size);
            end
            default: ;
        endcase
    end

    // fill*100/size > limit  <=>  fill*100 >= (limit+1)*size
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= r_status;
            r_out_slot   <= r_wr_idx;
            r_out_fval   <= r_fval;
            r_out_thr    <= (r_pa >= r_pb);
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.slot_index     = SLOT_OUT_W'(r_out_slot);
    assign o_rsp.found_value    = r_out_fval;
    assign o_rsp.over_threshold = r_out_thr;

    `OAHT_ALWAYS(a_fill_bound, r_fill <= SIZE_W'(SLOTS), "fill count above slot count")
    `OAHT_IMPLIES(a_probe_in_range, r_state == B_READ, r_idx < i_cfg.size,
        "probe index outside table")
    `OAHT_NEXT(a_fill_only_on_write, r_state != B_WRITE, $stable(r_fill),
        "fill count moved outside write")
    `OAHT_IMPLIES(a_no_pop_in_clear, r_state == B_CLEAR, !o_pop,
        "job taken during clearing pass")

endmodule

`default_nettype wire
